// File: sv/clock_wipe_row_runs_assert.svh
// Assertion macros shared by the clock wipe row run block.
`ifndef CLOCK_WIPE_ROW_RUNS_ASSERT_SVH
`define CLOCK_WIPE_ROW_RUNS_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define CWRR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cwrr assertion failed");

// Next-cycle implication, checked on every rising clock edge out of reset.
`define CWRR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cwrr assertion failed");

`endif

// File: sv/cwrr_pkg.sv
// Types, constants and helpers shared by the clock wipe row run block.
package cwrr_pkg;

  localparam int MAX_DIM_BITS    = 12;
  localparam int SLOPE_FRAC_BITS = 16;

  localparam int DIM_W      = 13;
  localparam int HALF_W     = DIM_W - 1;
  localparam int ROW_W      = 12;
  localparam int STEP_W     = 16;
  localparam int SLOPE_W    = 28;
  localparam int PROD_W     = ROW_W + SLOPE_W;
  localparam int RUN_W      = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 28;

  localparam logic [DIM_W:0] DIM_HI = (DIM_W + 1)'(1) << MAX_DIM_BITS;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCREEN_WIDTH  = 3'd0,
    REG_SCREEN_HEIGHT = 3'd1,
    REG_STEP_NOW      = 3'd2,
    REG_STEP_TOTAL    = 3'd3,
    REG_HAND_SLOPE    = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    PH_FIRST,
    PH_LAST,
    PH_Q1,
    PH_Q2,
    PH_Q3,
    PH_Q4
  } phase_t;

  typedef struct packed {
    logic [DIM_W-1:0]   width;
    logic [HALF_W-1:0]  cx;
    logic [HALF_W-1:0]  cy;
    logic [SLOPE_W-1:0] slope;
    phase_t             phase;
  } geom_t;

  typedef struct packed {
    logic              valid;
    logic              upper;
    logic [PROD_W-1:0] prod;
  } mid_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] res;
    if (v == '0) begin
      res = DIM_W'(1);
    end else if ({1'b0, v} > DIM_HI) begin
      res = DIM_HI[DIM_W-1:0];
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

// File: sv/cwrr_if.sv
// Handshake channel interfaces for row requests, row runs and register writes.
interface cwrr_in_if;
  logic                          valid;
  logic                          ready;
  logic [cwrr_pkg::ROW_W-1:0]    row_index;

  modport source (output valid, output row_index, input ready);
  modport sink   (input valid, input row_index, output ready);
endinterface

interface cwrr_out_if;
  logic                          valid;
  logic                          ready;
  logic [cwrr_pkg::RUN_W-1:0]    old_run_a;
  logic [cwrr_pkg::RUN_W-1:0]    new_run_a;
  logic [cwrr_pkg::RUN_W-1:0]    old_run_b;
  logic [cwrr_pkg::RUN_W-1:0]    new_run_b;

  modport source (output valid, output old_run_a, output new_run_a,
                  output old_run_b, output new_run_b, input ready);
  modport sink   (input valid, input old_run_a, input new_run_a,
                  input old_run_b, input new_run_b, output ready);
endinterface

interface cwrr_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [cwrr_pkg::CFG_IDX_W-1:0]  index;
  logic [cwrr_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: sv/cwrr_cfg.sv
// Configuration registers, dimension clamping and wipe phase decode.
module cwrr_cfg (
  input  logic                clk,
  input  logic                rst_n,
  cwrr_cfg_if.sink            cfg_ch,
  output cwrr_pkg::geom_t     geom
);

  logic [cwrr_pkg::DIM_W-1:0]   width_r;
  logic [cwrr_pkg::DIM_W-1:0]   height_r;
  logic [cwrr_pkg::STEP_W-1:0]  step_now_r;
  logic [cwrr_pkg::STEP_W-1:0]  step_total_r;
  logic [cwrr_pkg::SLOPE_W-1:0] slope_r;

  logic [cwrr_pkg::DIM_W-1:0]   w_clamp;
  logic [cwrr_pkg::DIM_W-1:0]   h_clamp;
  logic [cwrr_pkg::STEP_W-1:0]  total;
  logic [cwrr_pkg::STEP_W-1:0]  step;
  logic [cwrr_pkg::STEP_W+1:0]  total_x3;
  logic [cwrr_pkg::STEP_W-1:0]  q1_lim;
  logic [cwrr_pkg::STEP_W-1:0]  q2_lim;
  logic [cwrr_pkg::STEP_W-1:0]  q3_lim;
  cwrr_pkg::phase_t             phase;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r      <= cwrr_pkg::DIM_W'(640);
      height_r     <= cwrr_pkg::DIM_W'(480);
      step_now_r   <= '0;
      step_total_r <= cwrr_pkg::STEP_W'(1);
      slope_r      <= '0;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cwrr_pkg::cfg_reg_t'(cfg_ch.index))
        cwrr_pkg::REG_SCREEN_WIDTH:  width_r      <= cfg_ch.data[cwrr_pkg::DIM_W-1:0];
        cwrr_pkg::REG_SCREEN_HEIGHT: height_r     <= cfg_ch.data[cwrr_pkg::DIM_W-1:0];
        cwrr_pkg::REG_STEP_NOW:      step_now_r   <= cfg_ch.data[cwrr_pkg::STEP_W-1:0];
        cwrr_pkg::REG_STEP_TOTAL:    step_total_r <= cfg_ch.data[cwrr_pkg::STEP_W-1:0];
        cwrr_pkg::REG_HAND_SLOPE:    slope_r      <= cfg_ch.data[cwrr_pkg::SLOPE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    w_clamp  = cwrr_pkg::clamp_dim(width_r);
    h_clamp  = cwrr_pkg::clamp_dim(height_r);
    total    = (step_total_r == '0) ? cwrr_pkg::STEP_W'(1) : step_total_r;
    step     = (step_now_r > total) ? total : step_now_r;
    total_x3 = {1'b0, total, 1'b0} + {2'b00, total};
    q1_lim   = total >> 2;
    q2_lim   = total >> 1;
    q3_lim   = total_x3[cwrr_pkg::STEP_W+1:2];
  end

  always_comb begin
    if (step == '0) begin
      phase = cwrr_pkg::PH_FIRST;
    end else if (step == total) begin
      phase = cwrr_pkg::PH_LAST;
    end else if (step <= q1_lim) begin
      phase = cwrr_pkg::PH_Q1;
    end else if (step <= q2_lim) begin
      phase = cwrr_pkg::PH_Q2;
    end else if (step <= q3_lim) begin
      phase = cwrr_pkg::PH_Q3;
    end else begin
      phase = cwrr_pkg::PH_Q4;
    end
  end

  assign geom.width = w_clamp;
  assign geom.cx    = w_clamp[cwrr_pkg::DIM_W-1:1];
  assign geom.cy    = h_clamp[cwrr_pkg::DIM_W-1:1];
  assign geom.slope = slope_r;
  assign geom.phase = phase;

endmodule

// File: sv/cwrr_mul.sv
// Row distance from center times hand slope, registered product stage.
module cwrr_mul (
  input  logic                clk,
  input  logic                rst_n,
  cwrr_in_if.sink             in_ch,
  input  cwrr_pkg::geom_t     geom,
  input  logic                take,
  output cwrr_pkg::mid_t      mid
);

  logic                          valid_r;
  logic                          upper_r;
  logic [cwrr_pkg::PROD_W-1:0]   prod_r;

  logic                          upper;
  logic [cwrr_pkg::ROW_W-1:0]    row_off;
  logic [cwrr_pkg::PROD_W-1:0]   prod_nxt;

  assign in_ch.ready = !valid_r || take;

  always_comb begin
    upper    = in_ch.row_index <= geom.cy;
    row_off  = upper ? (geom.cy - in_ch.row_index) : (in_ch.row_index - geom.cy);
    prod_nxt = cwrr_pkg::PROD_W'(row_off) * cwrr_pkg::PROD_W'(geom.slope);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      upper_r <= upper;
      prod_r  <= prod_nxt;
    end
  end

  assign mid.valid = valid_r;
  assign mid.upper = upper_r;
  assign mid.prod  = prod_r;

endmodule

// File: sv/cwrr_runs.sv
// Rounding, hand offset limit and run selection into the result register.
module cwrr_runs (
  input  logic                clk,
  input  logic                rst_n,
  input  cwrr_pkg::geom_t     geom,
  input  cwrr_pkg::mid_t      mid,
  output logic                take,
  cwrr_out_if.source          out_ch
);

  localparam logic [cwrr_pkg::PROD_W:0] HALF_LSB =
    (cwrr_pkg::PROD_W + 1)'(1) << (cwrr_pkg::SLOPE_FRAC_BITS - 1);

  logic                          valid_r;
  logic [cwrr_pkg::RUN_W-1:0]    old_a_r, new_a_r, old_b_r, new_b_r;
  logic [cwrr_pkg::RUN_W-1:0]    old_a_nxt, new_a_nxt, old_b_nxt, new_b_nxt;

  logic [cwrr_pkg::PROD_W:0]     rounded;
  logic [cwrr_pkg::PROD_W:0]     xr;
  logic [cwrr_pkg::HALF_W-1:0]   x;
  logic [cwrr_pkg::RUN_W-1:0]    cx_w;
  logic [cwrr_pkg::RUN_W-1:0]    x_w;
  logic [cwrr_pkg::RUN_W-1:0]    w_w;
  logic [cwrr_pkg::RUN_W-1:0]    sum_a;

  assign take = !valid_r || out_ch.ready;

  always_comb begin
    rounded = {1'b0, mid.prod} + HALF_LSB;
    xr      = rounded >> cwrr_pkg::SLOPE_FRAC_BITS;
    x       = (xr > (cwrr_pkg::PROD_W + 1)'(geom.cx)) ? geom.cx : xr[cwrr_pkg::HALF_W-1:0];
    cx_w    = cwrr_pkg::RUN_W'(geom.cx);
    x_w     = cwrr_pkg::RUN_W'(x);
    w_w     = cwrr_pkg::RUN_W'(geom.width);
    sum_a   = cx_w + x_w;
  end

  always_comb begin
    old_a_nxt = '0;
    new_a_nxt = '0;
    old_b_nxt = '0;
    new_b_nxt = '0;
    case (geom.phase)
      cwrr_pkg::PH_FIRST: begin
        old_a_nxt = w_w;
      end
      cwrr_pkg::PH_LAST: begin
        new_a_nxt = w_w;
      end
      cwrr_pkg::PH_Q1: begin
        if (mid.upper) begin
          old_a_nxt = cx_w;
          new_a_nxt = x_w;
          old_b_nxt = cx_w - x_w;
        end else begin
          old_a_nxt = w_w;
        end
      end
      cwrr_pkg::PH_Q2: begin
        if (mid.upper) begin
          old_a_nxt = cx_w;
          new_a_nxt = cx_w;
        end else begin
          old_a_nxt = sum_a;
          new_a_nxt = cx_w - x_w;
        end
      end
      cwrr_pkg::PH_Q3: begin
        if (mid.upper) begin
          old_a_nxt = cx_w;
          new_a_nxt = cx_w;
        end else begin
          old_a_nxt = cx_w - x_w;
          new_a_nxt = (sum_a > w_w) ? w_w : sum_a;
        end
      end
      cwrr_pkg::PH_Q4: begin
        if (mid.upper) begin
          new_a_nxt = cx_w - x_w;
          old_b_nxt = x_w;
          new_b_nxt = cx_w;
        end else begin
          new_a_nxt = w_w;
        end
      end
      default: begin
        old_a_nxt = w_w;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= mid.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && mid.valid) begin
      old_a_r <= old_a_nxt;
      new_a_r <= new_a_nxt;
      old_b_r <= old_b_nxt;
      new_b_r <= new_b_nxt;
    end
  end

  assign out_ch.valid     = valid_r;
  assign out_ch.old_run_a = old_a_r;
  assign out_ch.new_run_a = new_a_r;
  assign out_ch.old_run_b = old_b_r;
  assign out_ch.new_run_b = new_b_r;

endmodule

// File: sv/clock_wipe_row_runs.sv
// Clock-hand wipe row runs: one scanline request in, four alternating run lengths out.
// The block takes one row request per clock while the request side is ready. The first
// stage forms the row's distance from the screen center and multiplies it by the hand
// slope into a product register; the second stage rounds the product, limits it to half
// the width and selects the runs into the output register. Sustained throughput is one
// row per cycle as long as results are taken; with the result side stalled, one more
// request is held in the product stage before the request side stalls. Runs are old,
// new, old, new, summing to the clamped width or to twice the center column.
// Registers are written through the configuration channel, which is always ready;
// write them only while no row is in flight.
`include "clock_wipe_row_runs_assert.svh"

module clock_wipe_row_runs (
  input  logic         clk,
  input  logic         rst_n,
  cwrr_in_if.sink      in_ch,
  cwrr_out_if.source   out_ch,
  cwrr_cfg_if.sink     cfg_ch
);

  cwrr_pkg::geom_t geom;
  cwrr_pkg::mid_t  mid;
  logic            take;

  cwrr_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .geom   (geom)
  );

  cwrr_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .geom  (geom),
    .take  (take),
    .mid   (mid)
  );

  cwrr_runs u_runs (
    .clk    (clk),
    .rst_n  (rst_n),
    .geom   (geom),
    .mid    (mid),
    .take   (take),
    .out_ch (out_ch)
  );

  `CWRR_ASSERT_NXT(a_accept_fills_mid, in_ch.valid && in_ch.ready, mid.valid)
  `CWRR_ASSERT_NXT(a_mid_moves_to_out, mid.valid && !out_ch.valid, out_ch.valid)
  `CWRR_ASSERT_IMP(a_full_blocks_input, mid.valid && out_ch.valid && !out_ch.ready, !in_ch.ready)

endmodule
